/* src/rrd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rrd_pkg: shared types and constants of the reversible ring deque
// Item formats, action and status codes, ring sizing and the control states.
// ----------------------------------------------------------------------------
package rrd_pkg;

   localparam int DEPTH   = 64;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int ELEM_W  = 32;
   localparam int COUNT_W = 7;

   typedef enum logic [2:0] {
      ACT_APPEND    = 3'd0,
      ACT_PREPEND   = 3'd1,
      ACT_DEL_FRONT = 3'd2,
      ACT_DEL_BACK  = 3'd3,
      ACT_REVERSE   = 3'd4,
      ACT_DUMP      = 3'd5
   } action_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_DUMP = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic [2:0]        action;
      logic [ELEM_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [ELEM_W-1:0]  element;
      logic [1:0]         status;
      logic [COUNT_W-1:0] count;
      logic               last;
   } rsp_type;

endpackage
`default_nettype wire

/* src/reversible_ring_deque_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// reversible_ring_deque_unit: bounded double-ended store on a ring buffer
// Elements sit in a RAM ring; a direction flag makes reverse a flag flip.
//
//   channel   direction   handshake            payload
//   req_      in          req_valid/req_stall  req_data  (req_type)
//   rsp_      out         rsp_valid/rsp_stall  rsp_data  (rsp_type)
//
// Insert, delete, reverse and an empty dump each give one response item.
// A dump of n elements gives n items after a registered RAM read: one element
// per cycle unless stalled, each read issued as the previous element is registered.
// Reset clears the pointers, count and flag; the RAM contents are not cleared.
// A new item is taken only in the idle state and while the output register
// is free or being emptied; a stalled output holds the dump in place.
// ----------------------------------------------------------------------------
module reversible_ring_deque_unit
   import rrd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   ctrl_state_type     state_ff, state_in;
   logic [ADDR_W-1:0]  front_ff, front_in;
   logic [CNT_W-1:0]   held_ff, held_in;
   logic               rev_ff, rev_in;
   logic [ADDR_W-1:0]  k_ff, k_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               out_free;
   logic               accept;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ELEM_W-1:0]  rd_data;
   logic               dump_last;
   logic [1:0]         st;
   logic               to_phys_back;
   logic               from_phys_front;

   // Folds a sum below twice the depth back into the ring.
   function automatic logic [ADDR_W-1:0] ring(input logic [CNT_W:0] a);
      logic [CNT_W:0] r;
      r = a;
      if (a >= (CNT_W+1)'(DEPTH)) begin
         r = a - (CNT_W+1)'(DEPTH);
      end
      return r[ADDR_W-1:0];
   endfunction

   // Physical slot of the k-th element in logical order.
   function automatic logic [ADDR_W-1:0] slot_of(
      input logic [ADDR_W-1:0] front,
      input logic [CNT_W-1:0]  held,
      input logic              rev,
      input logic [ADDR_W-1:0] k
   );
      logic [CNT_W:0] s;
      if (rev) begin
         s = (CNT_W+1)'(front) + (CNT_W+1)'(held) - (CNT_W+1)'(k) - (CNT_W+1)'(1);
      end else begin
         s = (CNT_W+1)'(front) + (CNT_W+1)'(k);
      end
      return ring(s);
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign dump_last = ((CNT_W+1)'(k_ff) + (CNT_W+1)'(1)) == (CNT_W+1)'(held_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   rrd_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         held_ff      <= '0;
         rev_ff       <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         held_ff      <= held_in;
         rev_ff       <= rev_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in        = state_ff;
      front_in        = front_ff;
      held_in         = held_ff;
      rev_in          = rev_ff;
      k_in            = k_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_data_in     = rsp_data_ff;
      wr_en           = 1'b0;
      wr_addr         = ring((CNT_W+1)'(front_ff) + (CNT_W+1)'(held_ff));
      rd_en           = 1'b0;
      rd_addr         = slot_of(front_ff, held_ff, rev_ff, '0);
      st              = ST_OK;
      to_phys_back    = ((action_type'(req_data.action) == ACT_APPEND) == !rev_ff);
      from_phys_front = ((action_type'(req_data.action) == ACT_DEL_FRONT) == !rev_ff);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (action_type'(req_data.action))
                  ACT_APPEND, ACT_PREPEND: begin
                     if (held_ff == CNT_W'(DEPTH)) begin
                        st = ST_FULL;
                     end else if (to_phys_back) begin
                        wr_en   = 1'b1;
                        held_in = held_ff + CNT_W'(1);
                     end else begin
                        front_in = ring((CNT_W+1)'(front_ff) + (CNT_W+1)'(DEPTH - 1));
                        wr_addr  = front_in;
                        wr_en    = 1'b1;
                        held_in  = held_ff + CNT_W'(1);
                     end
                  end
                  ACT_DEL_FRONT, ACT_DEL_BACK: begin
                     if (held_ff == '0) begin
                        st = ST_EMPTY;
                     end else if (from_phys_front) begin
                        front_in = ring((CNT_W+1)'(front_ff) + (CNT_W+1)'(1));
                        held_in  = held_ff - CNT_W'(1);
                     end else begin
                        held_in = held_ff - CNT_W'(1);
                     end
                  end
                  ACT_REVERSE: begin
                     if (held_ff != '0) begin
                        rev_in = !rev_ff;
                     end
                  end
                  ACT_DUMP: begin
                     if (held_ff == '0) begin
                        st = ST_EMPTY;
                     end
                  end
                  default: begin
                     st = ST_OK;
                  end
               endcase

               if ((action_type'(req_data.action) == ACT_DUMP) && (held_ff != '0)) begin
                  // Fetch the front element now; results follow from the dump state.
                  rd_en    = 1'b1;
                  k_in     = '0;
                  state_in = S_DUMP;
               end else begin
                  rsp_valid_in        = 1'b1;
                  rsp_data_in.element = '0;
                  rsp_data_in.status  = st;
                  rsp_data_in.count   = COUNT_W'(held_in);
                  rsp_data_in.last    = 1'b1;
               end
            end
         end
         S_DUMP: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.element = rd_data;
               rsp_data_in.status  = ST_OK;
               rsp_data_in.count   = COUNT_W'(held_ff);
               rsp_data_in.last    = dump_last;
               if (dump_last) begin
                  state_in = S_IDLE;
               end else begin
                  k_in    = k_ff + ADDR_W'(1);
                  rd_en   = 1'b1;
                  rd_addr = slot_of(front_ff, held_ff, rev_ff, k_in);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

/* src/rrd_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rrd_ram: generic single-clock RAM
// One write port and one read port; read data is registered and holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module rrd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic                             rd_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire
